@@ design/stack_watermark_monitor_macros.svh @@
// ----------------------------------------------------------------------------
// Stack watermark monitor assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STACK_WATERMARK_MONITOR_MACROS_SVH
`define STACK_WATERMARK_MONITOR_MACROS_SVH

// Condition must hold at every edge outside reset.
`define SWM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// Stack watermark monitor package
// Shared widths, reset values, register indexes and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

	localparam int WORD_W       = 32;
	localparam int SIZE_W       = 17;
	localparam int BYTES_W      = 16;
	localparam int COUNT_W      = 14;
	localparam int PCT_W        = 7;
	localparam int QUOT_BITS    = 7;
	localparam int DIVIDEND_W   = 23;
	localparam int CFG_IDX_W    = 2;

	localparam int MAX_STACK_BYTES_DEF = 65536;
	localparam int OUT_SIZE_CAP        = 65536;
	localparam int WORD_BYTES          = 4;
	localparam int PCT_SCALE           = 100;

	localparam logic [WORD_W-1:0] TOP_RESET  = 32'h2000_7FFC;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd4096;
	localparam logic [WORD_W-1:0] FILL_RESET = 32'h0ABA_DD1E;
	localparam logic [WORD_W-1:0] END_RESET  = 32'h0ABA_DA55;

	localparam logic [CFG_IDX_W-1:0] REG_STACK_TOP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STACK_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILL       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END        = 2'd3;

	// divider status toward the top level
	typedef struct packed {
		logic busy;   // iterating or result not yet taken
		logic done;   // quotient valid this cycle
	} div_status_t;

endpackage

@@ design/swm_scan.sv @@
// ----------------------------------------------------------------------------
// Stack watermark scan tracker
// Checks the end-marker word and counts leading fill-marker words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_scan
	import swm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               last,
	input  logic [WORD_W-1:0]  word,
	input  logic [WORD_W-1:0]  fill_marker,
	input  logic [WORD_W-1:0]  end_marker,
	input  logic [COUNT_W-1:0] word_cap,
	output logic [COUNT_W-1:0] count_nxt,
	output logic               end_ok_nxt
);

	logic               first_q;
	logic               scan_q;
	logic [COUNT_W-1:0] count_q;
	logic               end_ok_q;
	logic               scan_n;

	always_comb begin
		count_nxt  = count_q;
		end_ok_nxt = end_ok_q;
		scan_n     = scan_q;
		if (first_q) begin
			end_ok_nxt = (word == end_marker);
		end else if (scan_q) begin
			if (word == fill_marker) begin
				if (count_q < word_cap) begin
					count_nxt = count_q + COUNT_W'(1);
				end
			end else begin
				scan_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= 1'b1;
			scan_q   <= 1'b1;
			count_q  <= '0;
			end_ok_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				// rearm for the next scan
				first_q  <= 1'b1;
				scan_q   <= 1'b1;
				count_q  <= '0;
				end_ok_q <= 1'b0;
			end else begin
				first_q  <= 1'b0;
				scan_q   <= scan_n;
				count_q  <= count_nxt;
				end_ok_q <= end_ok_nxt;
			end
		end
	end

endmodule

@@ design/swm_div.sv @@
// ----------------------------------------------------------------------------
// Stack watermark percent divider
// Restoring divider, one quotient bit per cycle; zero divisor gives zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_div
	import swm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [BYTES_W-1:0]    divisor,
	output div_status_t           status,
	output logic [QUOT_BITS-1:0]  quotient
);

	localparam int CNT_W = $clog2(QUOT_BITS);
	localparam int SHIFT = QUOT_BITS - 1;

	logic [DIVIDEND_W-1:0] rem_q;
	logic [DIVIDEND_W-1:0] dsr_q;
	logic [QUOT_BITS-1:0]  quot_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  zero_q;
	logic [DIVIDEND_W:0]   diff;
	logic                  ge;

	// one shared subtract and compare per step
	assign diff = {1'b0, rem_q} - {1'b0, dsr_q};
	assign ge   = !diff[DIVIDEND_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SHIFT);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsr_q  <= DIVIDEND_W'({divisor, SHIFT'(0)});
			quot_q <= '0;
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[DIVIDEND_W-1:0];
			end
			quot_q <= {quot_q[QUOT_BITS-2:0], ge};
			dsr_q  <= dsr_q >> 1;
		end
	end

	assign status.busy = busy_q | done_q;
	assign status.done = done_q;
	assign quotient    = zero_q ? '0 : quot_q;

endmodule

@@ design/stack_watermark_monitor.sv @@
// ----------------------------------------------------------------------------
// Stack watermark monitor
// Scans a painted stack bottom-up and reports free, used, percent, corrupt.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one stack word per word, lowest
//   address first. The first word of a scan is checked against end_marker,
//   later words are counted while they equal fill_marker. last_word ends
//   the scan; stack_pointer is sampled with it.
//   Ordinary words are taken one per cycle. A last word is held off while
//   the percent divider runs or a result still waits in the output register.
//   Output channel (out_valid / out_stall): one result word per scan,
//   presented once the edge that takes the last word has captured the job,
//   7 divider steps have followed (one quotient bit each on the shared
//   subtractor) and the result has loaded. With no output stall the next
//   last word can be taken once that result has left the output register.
//   A stalled result holds in the output register; words of the next scan
//   keep flowing in meanwhile.
//   Configuration: cfg_we with cfg_index / cfg_data, written only when idle by
//   the user; the block does not enforce it. Reset: registers return to their
//   defaults, the scan rearms, no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stack_watermark_monitor_macros.svh"

module stack_watermark_monitor
	import swm_pkg::*;
#(
	parameter int MAX_STACK_BYTES = MAX_STACK_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WORD_W-1:0]    stack_word,
	input  logic                 last_word,
	input  logic [WORD_W-1:0]    stack_pointer,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTES_W-1:0]   free_bytes,
	output logic [BYTES_W-1:0]   used_bytes,
	output logic [PCT_W-1:0]     usage_percent,
	output logic                 corrupted
);

	// effective size cap: the smaller of the build limit and the output range
	localparam int CAP_BYTES = (MAX_STACK_BYTES < OUT_SIZE_CAP) ? MAX_STACK_BYTES
		: OUT_SIZE_CAP;

	// configuration registers
	logic [WORD_W-1:0] top_q;
	logic [SIZE_W-1:0] size_q;
	logic [WORD_W-1:0] fill_q;
	logic [WORD_W-1:0] end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= TOP_RESET;
			size_q <= SIZE_RESET;
			fill_q <= FILL_RESET;
			end_q  <= END_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STACK_TOP:  top_q  <= cfg_data;
				REG_STACK_SIZE: size_q <= cfg_data[SIZE_W-1:0];
				REG_FILL:       fill_q <= cfg_data;
				REG_END:        end_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// usable bytes exclude the end-marker word; never negative
	logic [SIZE_W-1:0]  size_eff;
	logic [BYTES_W-1:0] usable;
	logic [COUNT_W-1:0] word_cap;

	always_comb begin
		size_eff = (size_q > SIZE_W'(CAP_BYTES)) ? SIZE_W'(CAP_BYTES) : size_q;
		usable   = (size_eff >= SIZE_W'(WORD_BYTES))
			? BYTES_W'(size_eff - SIZE_W'(WORD_BYTES)) : '0;
		// usable tops out at 65532, so usable/4 already fits the 14-bit limit
		word_cap = usable[BYTES_W-1:2];
	end

	// handshake
	div_status_t div_st;
	logic        out_valid_q;
	logic        in_accept;
	logic        finish;

	// a last word needs the divider and the output register free
	assign in_stall  = last_word && (div_st.busy || out_valid_q);
	assign in_accept = in_valid && !in_stall;
	assign finish    = in_accept && last_word;

	// scan tracking
	logic [COUNT_W-1:0] count_nxt;
	logic               end_ok_nxt;

	swm_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.last        (last_word),
		.word        (stack_word),
		.fill_marker (fill_q),
		.end_marker  (end_q),
		.word_cap    (word_cap),
		.count_nxt   (count_nxt),
		.end_ok_nxt  (end_ok_nxt)
	);

	// end-of-scan figures, computed in the capture cycle
	logic [COUNT_W-1:0]    words;
	logic [BYTES_W-1:0]    free_b;
	logic [BYTES_W-1:0]    used_b;
	logic [WORD_W-1:0]     bottom;
	logic                  corrupt;
	logic [DIVIDEND_W-1:0] dividend;

	always_comb begin
		words    = (count_nxt > word_cap) ? word_cap : count_nxt;
		free_b   = {words, 2'b00};
		used_b   = (usable > free_b) ? (usable - free_b) : '0;
		// bottom uses the raw size register, wrapping mod 2^32
		bottom   = top_q - WORD_W'(size_q) + WORD_W'(WORD_BYTES);
		corrupt  = !end_ok_nxt || (stack_pointer <= bottom);
		dividend = DIVIDEND_W'(used_b) * DIVIDEND_W'(PCT_SCALE);
	end

	// job registers held while the divider runs
	logic [BYTES_W-1:0] free_job_q;
	logic [BYTES_W-1:0] used_job_q;
	logic               corrupt_job_q;

	always_ff @(posedge clk) begin
		if (finish) begin
			free_job_q    <= free_b;
			used_job_q    <= used_b;
			corrupt_job_q <= corrupt;
		end
	end

	logic [QUOT_BITS-1:0] quotient;

	swm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (finish),
		.dividend (dividend),
		.divisor  (usable),
		.status   (div_st),
		.quotient (quotient)
	);

	// output register
	logic [BYTES_W-1:0] free_q;
	logic [BYTES_W-1:0] used_q;
	logic [PCT_W-1:0]   pct_q;
	logic               corrupt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_st.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_st.done) begin
			free_q    <= free_job_q;
			used_q    <= used_job_q;
			pct_q     <= (quotient > QUOT_BITS'(PCT_SCALE)) ? PCT_W'(PCT_SCALE)
				: PCT_W'(quotient);
			corrupt_q <= corrupt_job_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign free_bytes    = free_q;
	assign used_bytes    = used_q;
	assign usage_percent = pct_q;
	assign corrupted     = corrupt_q;

	// checks
	`SWM_ASSERT_ALWAYS(a_no_overlap, !(div_st.done && out_valid_q), "result overwrites pending word")
	`SWM_ASSERT_NEXT(a_done_shows, div_st.done, out_valid, "finished division not presented")
	`SWM_ASSERT_NEXT(a_finish_runs, finish, div_st.busy, "last word did not start divider")
	`SWM_ASSERT_ALWAYS(a_pct_range, !out_valid || (usage_percent <= PCT_W'(PCT_SCALE)), "percent above limit")

endmodule
